[rtl/sac_pkg.sv]
// shared types and codes for the source admission control block
package sac_pkg;

  // one table entry as held in the table memory
  typedef struct packed {
    logic        banned;
    logic        warned;
    logic [31:0] last_seen;
    logic [31:0] addr;
  } entry_t;

  // result codes carried on the verdict port
  typedef enum logic [2:0] {
    V_NEW   = 3'd0,
    V_KNOWN = 3'd1,
    V_WARN  = 3'd2,
    V_BAN   = 3'd3,
    V_DROP  = 3'd4,
    V_FULL  = 3'd5
  } verdict_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  localparam logic [15:0] MIN_GAP_RESET = 16'd10;

endpackage

[rtl/sac_table.sv]
// source table memory: one write port, one registered read port
module sac_table
  import sac_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int IDX_W         = 6
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_entry,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  entry_t           wr_entry
);

  entry_t mem [TABLE_ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  // read port, registered, data held while not reading
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_idx];
    end
  end

endmodule

[rtl/source_admission_control.sv]
// top level of the per-source admission control block
// Each request (source address, time in seconds) is looked up in a table of
// TABLE_ENTRIES sources held in one memory. It is answered with one verdict and
// the table entry used. The idle state takes the request. The scan state then
// reads the table memory one entry per cycle, in order, until a match or the
// end of the entries in use, and compares each entry read with the request
// address. The finish state then decides, writes the entry back unless the
// verdict is drop or full, and loads the verdict into the output register.
// One request is worked on at a time. The next request is taken while the
// previous verdict still waits in the output register. The decide cycle
// stalls for as long as that earlier verdict is not taken. Entries are filled
// in order and never freed, so a fill count marks which entries are in use:
// there is no clearing pass after reset. The minimum gap register (reset 10
// seconds) is written with cfg_write_en.
module source_admission_control
  import sac_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] src_addr,
  input  logic [31:0] now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  verdict,
  output logic [5:0]  slot
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

  state_t           state, state_next;
  logic [15:0]      min_gap_seconds;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] scan_idx;
  logic [IDX_W-1:0] chk_idx;
  logic             chk_vld;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [31:0]      req_addr;
  logic [31:0]      req_now;

  logic             rd_en;
  entry_t           rd_entry;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_entry;

  logic             scan_match;
  logic             scan_more;
  logic             finish_go;
  verdict_t         res_verdict;
  logic [IDX_W-1:0] res_idx;
  logic [IDX_W+5:0] res_idx_ext;
  logic             fill_inc;
  logic [31:0]      elapsed;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap_seconds <= MIN_GAP_RESET;
    end else if (cfg_write_en) begin
      min_gap_seconds <= cfg_write_data;
    end
  end

  // table memory
  sac_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_table (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_idx   (scan_idx[IDX_W-1:0]),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_entry (wr_entry)
  );

  // scan compare and read issue
  assign scan_match = chk_vld && (rd_entry.addr == req_addr);
  assign scan_more  = scan_idx < fill_count;
  assign finish_go  = !out_valid || out_ready;
  assign in_ready   = (state == ST_IDLE);
  assign elapsed    = req_now - rd_entry.last_seen;

  // next state, memory write and verdict
  always_comb begin
    state_next  = state;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_idx      = hit_idx;
    wr_entry    = rd_entry;
    res_verdict = V_FULL;
    res_idx     = '0;
    fill_inc    = 1'b0;

    if (hit) begin
      res_idx = hit_idx;
      if (rd_entry.banned) begin
        res_verdict = V_DROP;
      end else begin
        wr_entry.last_seen = req_now;
        if (elapsed < {16'd0, min_gap_seconds}) begin
          if (rd_entry.warned) begin
            wr_entry.banned = 1'b1;
            res_verdict     = V_BAN;
          end else begin
            wr_entry.warned = 1'b1;
            res_verdict     = V_WARN;
          end
        end else begin
          res_verdict = V_KNOWN;
        end
      end
    end else if (fill_count < FULL_COUNT) begin
      res_verdict        = V_NEW;
      res_idx            = fill_count[IDX_W-1:0];
      wr_idx             = fill_count[IDX_W-1:0];
      wr_entry.addr      = req_addr;
      wr_entry.last_seen = req_now;
      wr_entry.warned    = 1'b0;
      wr_entry.banned    = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_match) begin
          state_next = ST_FINISH;
        end else if (scan_more) begin
          rd_en = 1'b1;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_next = ST_IDLE;
          wr_en      = (res_verdict != V_DROP) && (res_verdict != V_FULL);
          fill_inc   = (res_verdict == V_NEW);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign res_idx_ext = (IDX_W + 6)'(res_idx);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scan control and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      scan_idx   <= '0;
      chk_vld    <= 1'b0;
      hit        <= 1'b0;
    end else begin
      if (fill_inc) begin
        fill_count <= fill_count + CNT_W'(1);
      end
      unique case (state)
        ST_IDLE: begin
          scan_idx <= '0;
          chk_vld  <= 1'b0;
          hit      <= 1'b0;
        end
        ST_SCAN: begin
          if (scan_match) begin
            hit     <= 1'b1;
            chk_vld <= 1'b0;
          end else begin
            chk_vld <= scan_more;
            if (scan_more) begin
              scan_idx <= scan_idx + CNT_W'(1);
            end
          end
        end
        default: begin
          chk_vld <= 1'b0;
        end
      endcase
    end
  end

  // request capture and scan payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_addr <= src_addr;
      req_now  <= now_seconds;
    end
    if (rd_en) begin
      chk_idx <= scan_idx[IDX_W-1:0];
    end
    if (state == ST_SCAN && scan_match) begin
      hit_idx <= chk_idx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && finish_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && finish_go) begin
      verdict <= res_verdict;
      slot    <= res_idx_ext[5:0];
    end
  end

  // checks on the table sequencer
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FULL_COUNT)
    else $error("fill count beyond table size");

  a_read_in_use: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (scan_idx < fill_count))
    else $error("table read beyond entries in use");

  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict == V_FULL) |-> (slot == 6'd0))
    else $error("untracked verdict with non-zero slot");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict <= V_FULL))
    else $error("verdict code out of range");

endmodule

[tb/tb.sv]
// testbench for the source admission control block: queued requests, table predictor, checks
`timescale 1ns / 100ps

module tb;
  import sac_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  // worst case lookup plus write-back, with some margin
  localparam int SETTLE_CYCLES = TABLE_ENTRIES + 8;
  localparam int PHASE_ITEMS = 290;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] now;
  } req_item_t;

  typedef struct {
    verdict_t   verdict;
    logic [5:0] slot;
  } judged_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [15:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] src_addr = '0;
  logic [31:0] now_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  verdict;
  logic [5:0]  slot;

  req_item_t  request_q[$];
  judged_t    expected_verdicts[$];
  idle_mode_t idle_mode = IDLE_NONE;
  bit         in_taken = 1'b0;
  int         fail_count = 0;
  int         gap_secs = MIN_GAP_RESET;

  // predictor copy of the source table
  bit          seen_valid[TABLE_ENTRIES];
  logic [31:0] seen_addr[TABLE_ENTRIES];
  logic [31:0] seen_last[TABLE_ENTRIES];
  bit          seen_warned[TABLE_ENTRIES];
  bit          seen_banned[TABLE_ENTRIES];
  int          fill_count = 0;

  // stimulus side view of the sources sent so far, in table order
  logic [31:0] pool_addr[TABLE_ENTRIES];
  logic [31:0] pool_last[TABLE_ENTRIES];
  int          pool_size = 0;

  req_item_t   next_req;
  judged_t     got;

  source_admission_control #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .src_addr      (src_addr),
    .now_seconds   (now_seconds),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .verdict       (verdict),
    .slot          (slot)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // expected verdict for one accepted request, updating the table copy
  task automatic judge_request(input logic [31:0] addr, input logic [31:0] now);
    int          hit;
    logic [31:0] elapsed;
    judged_t     res;
    hit = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (hit < 0 && seen_valid[i] && seen_addr[i] == addr) hit = i;
    res.slot = '0;
    if (hit < 0) begin
      if (fill_count < TABLE_ENTRIES) begin
        seen_valid[fill_count] = 1'b1;
        seen_addr[fill_count] = addr;
        seen_last[fill_count] = now;
        seen_warned[fill_count] = 1'b0;
        seen_banned[fill_count] = 1'b0;
        res.slot = 6'(fill_count);
        res.verdict = V_NEW;
        fill_count++;
      end else begin
        res.verdict = V_FULL;
      end
    end else begin
      res.slot = 6'(hit);
      if (seen_banned[hit]) begin
        res.verdict = V_DROP;
      end else begin
        // wrapping difference, too fast when under the gap
        elapsed = now - seen_last[hit];
        if (elapsed < 32'(gap_secs)) begin
          if (seen_warned[hit]) begin
            seen_banned[hit] = 1'b1;
            res.verdict = V_BAN;
          end else begin
            seen_warned[hit] = 1'b1;
            res.verdict = V_WARN;
          end
        end else begin
          res.verdict = V_KNOWN;
        end
        seen_last[hit] = now;
      end
    end
    expected_verdicts.push_back(res);
  endtask

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 85;
      IDLE_BOTH:   return $urandom_range(99) < 36;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 85;
      IDLE_BOTH:     return $urandom_range(99) < 36;
      default:       return 1'b0;
    endcase
  endfunction

  // driver: new payload and ready at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (request_q.size() != 0 && !sender_idles()) begin
          next_req = request_q.pop_front();
          in_valid <= 1'b1;
          src_addr <= next_req.addr;
          now_seconds <= next_req.now;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !receiver_stalls();
    end
    in_taken = 1'b0;
  end

  // monitor: request transfers feed the predictor, verdict transfers are checked
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        judge_request(src_addr, now_seconds);
      end
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: verdict transfer with none expected: verdict %0d slot %0d",
                   $time, verdict, slot);
          fail_count++;
        end else begin
          got = expected_verdicts.pop_front();
          if (verdict !== got.verdict) begin
            $display("%0t: verdict mismatch: expected %0d (%s), actual %0d",
                     $time, got.verdict, got.verdict.name(), verdict);
            fail_count++;
          end
          if (slot !== got.slot) begin
            $display("%0t: slot mismatch: expected %0d, actual %0d",
                     $time, got.slot, slot);
            fail_count++;
          end
        end
      end
    end
  end

  // queue one request and keep the stimulus view of the table in step
  task automatic push_request(input logic [31:0] addr, input logic [31:0] now);
    req_item_t r;
    int        k;
    k = -1;
    for (int i = 0; i < pool_size; i++)
      if (k < 0 && pool_addr[i] == addr) k = i;
    if (k < 0 && pool_size < TABLE_ENTRIES) begin
      k = pool_size;
      pool_addr[k] = addr;
      pool_size++;
    end
    if (k >= 0) pool_last[k] = now;
    r.addr = addr;
    r.now = now;
    request_q.push_back(r);
  endtask

  // mostly well-paced repeats of known sources, with bursts, new sources and noise
  task automatic queue_random_requests(input int count);
    int          pick;
    int          k;
    logic [31:0] t;
    repeat (count) begin
      pick = $urandom_range(99);
      k = $urandom_range(pool_size - 1);
      if (pick < 10) begin
        push_request($urandom, $urandom);
      end else if (pick < 20) begin
        push_request(pool_addr[k], $urandom);
      end else if (pick < 25) begin
        // too fast, or same second when the gap is zero
        t = pool_last[k];
        if (gap_secs > 0) t = t + $urandom_range(gap_secs - 1);
        push_request(pool_addr[k], t);
      end else begin
        t = pool_last[k] + 32'(gap_secs);
        if ($urandom_range(1)) t = t + $urandom_range(20);
        else t = t + $urandom_range(32'h7fff_0000);
        push_request(pool_addr[k], t);
      end
    end
  endtask

  // hold off until every request is taken and every verdict is back
  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_gap(input int value);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= 16'(value);
    gap_secs = value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // overall time limit
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // reset, directed requests, then random phases
  initial begin
    int         gap_plan[5];
    idle_mode_t mode_plan[5];
    gap_plan[0] = 65535;
    gap_plan[1] = 0;
    gap_plan[2] = 1;
    gap_plan[3] = $urandom_range(65534, 2);
    gap_plan[4] = 10;
    mode_plan[0] = IDLE_NONE;
    mode_plan[1] = IDLE_SENDER;
    mode_plan[2] = IDLE_RECEIVER;
    mode_plan[3] = IDLE_BOTH;
    mode_plan[4] = IDLE_BOTH;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, warn then ban, drop, wrapping elapsed time
    push_request(32'h0000_0000, 32'h0000_0000);
    push_request(32'hffff_ffff, 32'hffff_ffff);
    push_request(32'h0000_0000, 32'd5);
    push_request(32'h0000_0000, 32'd15);
    push_request(32'h0000_0000, 32'd24);
    push_request(32'h0000_0000, 32'd100);
    push_request(32'hffff_ffff, 32'd8);
    push_request(32'hffff_ffff, 32'h0000_0012);
    push_request(32'hffff_ffff, 32'h0000_0012);
    push_request(32'ha5a5_a5a5, 32'h5a5a_5a5a);
    push_request(32'h5a5a_5a5a, 32'ha5a5_a5a5);
    push_request(32'ha5a5_a5a5, 32'h5a5a_5a50);
    push_request(32'h5a5a_5a5a, 32'ha5a5_a5ae);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      write_min_gap(gap_plan[ph]);
      idle_mode = mode_plan[ph];
      queue_random_requests(PHASE_ITEMS);
      wait_drained();
    end

    if (fail_count == 0 && expected_verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
